// ===== rtl/core/md5ws_pkg.sv =====
// Shared constants for the MD5 weight skinning unit.
// Used by the top level; depends on nothing.
package md5ws_pkg;

  localparam int JointCount = 64;
  localparam int JointAddrW = (JointCount > 1) ? $clog2(JointCount) : 1;

  // Joint table entry: {w, qz, qy, qx, pz, py, px} from the top bit down.
  localparam int JointEntryW = 3 * 32 + 4 * 16;

endpackage

// ===== rtl/core/md5ws_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module md5ws_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/core/md5_weight_skinning_unit.sv =====
// Top level of the MD5 weight skinning unit: joint table, shared multiplier sequencer,
// square-root iteration and vertex accumulators. Depends on md5ws_pkg and md5ws_ram.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o | operation .. last_weight
//   out     | output    | out_valid_o/out_ready_i | vert_x/y/z, saturated
//
// After a weight is transferred, the next item is taken only once the unit is back in
// idle: one joint table read and 19 steps of the weight sequencer around the single
// shared 18 x 40 multiplier. A joint load runs three squaring steps, 16 square-root
// iterations and the table write. A last weight also loads the output register,
// and waits there while the previous result has not been transferred.
// Reset clears control state and the accumulators; the joint table is not cleared.
module md5_weight_skinning_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [5:0]         joint_index_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic [16:0]        bias_i,
  input  logic               last_weight_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] vert_x_o,
  output logic signed [31:0] vert_y_o,
  output logic signed [31:0] vert_z_o,
  output logic               saturated_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StWMac = 3'd1;
  localparam logic [2:0] StJSq  = 3'd2;
  localparam logic [2:0] StJRt  = 3'd3;
  localparam logic [2:0] StJWr  = 3'd4;
  localparam logic [2:0] StEmit = 3'd5;

  localparam logic [4:0] WLastStep = 5'd18;

  typedef enum logic [1:0] {MacNone, MacLoad, MacAdd, MacSub} mac_mode_e;

  logic [2:0] state_q, state_d;
  logic [4:0] step_q, step_d;

  logic                      last_q;
  logic [md5ws_pkg::JointAddrW-1:0] idx_q;
  logic signed [31:0]        px_q, py_q, pz_q;
  logic signed [15:0]        qx_q, qy_q, qz_q;
  logic [16:0]               bias_q;

  logic signed [34:0] rx_q, ry_q, rz_q;
  logic signed [39:0] sx_q, sy_q, sz_q;
  logic signed [59:0] m_q, m_d;
  logic signed [47:0] acc_x_q, acc_y_q, acc_z_q;
  logic [32:0]        clamp_x, clamp_y, clamp_z;

  logic [31:0] sq_v_q, sq_r_q, sq_bit_q;
  logic [31:0] sq_v_d, sq_r_d, sq_sum;
  logic        sq_neg_q;
  logic signed [33:0] sq_t;

  logic                             ram_we, ram_re;
  logic [md5ws_pkg::JointEntryW-1:0] ram_wdata, ram_rdata;
  logic signed [31:0] jpx, jpy, jpz;
  logic signed [15:0] ux, uy, uz, uw, w_new;

  mac_mode_e          mac_mode;
  logic signed [17:0] mac_a;
  logic signed [39:0] mac_b;
  logic signed [57:0] prod;

  logic out_valid_q;
  logic in_xfer, emit_go;

  assign in_ready_o = (state_q == StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign emit_go    = (state_q == StEmit) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  assign jpx = ram_rdata[31:0];
  assign jpy = ram_rdata[63:32];
  assign jpz = ram_rdata[95:64];
  assign ux  = ram_rdata[111:96];
  assign uy  = ram_rdata[127:112];
  assign uz  = ram_rdata[143:128];
  assign uw  = ram_rdata[159:144];

  assign w_new     = sq_neg_q ? 16'sd0 : 16'(-sq_r_q);
  assign ram_we    = (state_q == StJWr);
  assign ram_re    = in_xfer && operation_i;
  assign ram_wdata = {w_new, qz_q, qy_q, qx_q, pz_q, py_q, px_q};

  md5ws_ram #(
    .Width(md5ws_pkg::JointEntryW),
    .Depth(md5ws_pkg::JointCount)
  ) u_joint_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(joint_index_i[md5ws_pkg::JointAddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  function automatic logic signed [47:0] sat_add(logic signed [47:0] a,
                                                logic signed [43:0] p);
    logic signed [48:0] s;
    s = 49'(a) + 49'(p);
    if (s[48] != s[47]) begin
      sat_add = s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      sat_add = s[47:0];
    end
  endfunction

  function automatic logic [32:0] clamp32(logic signed [47:0] a);
    // Low 32 bits are the clamped value, the top bit flags a clamp.
    if (a[47:31] == {17{a[47]}}) begin
      clamp32 = {1'b0, a[31:0]};
    end else begin
      clamp32 = {1'b1, a[47] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    end
  endfunction

  assign clamp_x = clamp32(acc_x_q);
  assign clamp_y = clamp32(acc_y_q);
  assign clamp_z = clamp32(acc_z_q);

  // Operand schedule of the shared multiplier.
  always_comb begin
    mac_mode = MacNone;
    mac_a    = '0;
    mac_b    = '0;
    if (state_q == StWMac) begin
      unique case (step_q)
        5'd0:  begin mac_mode = MacLoad; mac_a = 18'(uy); mac_b = 40'(pz_q); end
        5'd1:  begin mac_mode = MacSub;  mac_a = 18'(uz); mac_b = 40'(py_q); end
        5'd2:  begin mac_mode = MacLoad; mac_a = 18'(uz); mac_b = 40'(px_q); end
        5'd3:  begin mac_mode = MacSub;  mac_a = 18'(ux); mac_b = 40'(pz_q); end
        5'd4:  begin mac_mode = MacLoad; mac_a = 18'(ux); mac_b = 40'(py_q); end
        5'd5:  begin mac_mode = MacSub;  mac_a = 18'(uy); mac_b = 40'(px_q); end
        5'd6:  begin mac_mode = MacLoad; mac_a = 18'(uw); mac_b = 40'(rx_q); end
        5'd7:  begin mac_mode = MacLoad; mac_a = 18'(uw); mac_b = 40'(ry_q); end
        5'd8:  begin mac_mode = MacLoad; mac_a = 18'(uw); mac_b = 40'(rz_q); end
        5'd9:  begin mac_mode = MacLoad; mac_a = 18'(uy); mac_b = 40'(rz_q); end
        5'd10: begin mac_mode = MacSub;  mac_a = 18'(uz); mac_b = 40'(ry_q); end
        5'd11: begin mac_mode = MacLoad; mac_a = 18'(uz); mac_b = 40'(rx_q); end
        5'd12: begin mac_mode = MacSub;  mac_a = 18'(ux); mac_b = 40'(rz_q); end
        5'd13: begin mac_mode = MacLoad; mac_a = 18'(ux); mac_b = 40'(ry_q); end
        5'd14: begin mac_mode = MacSub;  mac_a = 18'(uy); mac_b = 40'(rx_q); end
        5'd15: begin mac_mode = MacLoad; mac_a = 18'(signed'({1'b0, bias_q})); mac_b = sx_q; end
        5'd16: begin mac_mode = MacLoad; mac_a = 18'(signed'({1'b0, bias_q})); mac_b = sy_q; end
        5'd17: begin mac_mode = MacLoad; mac_a = 18'(signed'({1'b0, bias_q})); mac_b = sz_q; end
        default: mac_mode = MacNone;
      endcase
    end else if (state_q == StJSq) begin
      unique case (step_q)
        5'd0:    begin mac_mode = MacLoad; mac_a = 18'(qx_q); mac_b = 40'(qx_q); end
        5'd1:    begin mac_mode = MacAdd;  mac_a = 18'(qy_q); mac_b = 40'(qy_q); end
        5'd2:    begin mac_mode = MacAdd;  mac_a = 18'(qz_q); mac_b = 40'(qz_q); end
        default: mac_mode = MacNone;
      endcase
    end
  end

  assign prod = mac_a * mac_b;

  always_comb begin
    case (mac_mode)
      MacLoad: m_d = 60'(prod);
      MacAdd:  m_d = m_q + 60'(prod);
      MacSub:  m_d = m_q - 60'(prod);
      default: m_d = m_q;
    endcase
  end

  // One step of the digit-by-digit square root.
  always_comb begin
    sq_sum = sq_r_q + sq_bit_q;
    if (sq_v_q >= sq_sum) begin
      sq_v_d = sq_v_q - sq_sum;
      sq_r_d = (sq_r_q >> 1) + sq_bit_q;
    end else begin
      sq_v_d = sq_v_q;
      sq_r_d = sq_r_q >> 1;
    end
  end

  assign sq_t = 34'sh0_4000_0000 - signed'(m_q[33:0]);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      StIdle: begin
        step_d = '0;
        if (in_xfer) begin
          state_d = operation_i ? StWMac : StJSq;
        end
      end
      StWMac: begin
        step_d = step_q + 5'd1;
        if (step_q == WLastStep) begin
          state_d = last_q ? StEmit : StIdle;
        end
      end
      StJSq: begin
        step_d = step_q + 5'd1;
        if (step_q == 5'd3) begin
          state_d = StJRt;
          step_d  = '0;
        end
      end
      StJRt: begin
        step_d = step_q + 5'd1;
        if (step_q == 5'd15) begin
          state_d = StJWr;
        end
      end
      StJWr:  state_d = StIdle;
      StEmit: if (emit_go) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      acc_z_q     <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (emit_go) begin
        out_valid_q <= 1'b1;
        acc_x_q     <= '0;
        acc_y_q     <= '0;
        acc_z_q     <= '0;
      end else begin
        if (out_ready_i) out_valid_q <= 1'b0;
        if (state_q == StWMac) begin
          if (step_q == 5'd16) acc_x_q <= sat_add(acc_x_q, m_q[59:16]);
          if (step_q == 5'd17) acc_y_q <= sat_add(acc_y_q, m_q[59:16]);
          if (step_q == 5'd18) acc_z_q <= sat_add(acc_z_q, m_q[59:16]);
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    m_q <= m_d;
    if (in_xfer) begin
      last_q <= last_weight_i;
      idx_q  <= joint_index_i[md5ws_pkg::JointAddrW-1:0];
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      pz_q   <= pos_z_i;
      qx_q   <= quat_x_i;
      qy_q   <= quat_y_i;
      qz_q   <= quat_z_i;
      bias_q <= bias_i;
    end
    if (state_q == StWMac) begin
      // Results are taken from the product of the step before.
      case (step_q)
        5'd2:  rx_q <= m_q[48:14];
        5'd4:  ry_q <= m_q[48:14];
        5'd6:  rz_q <= m_q[48:14];
        5'd7:  sx_q <= 40'(jpx) + 40'(px_q) + m_q[54:15];
        5'd8:  sy_q <= 40'(jpy) + 40'(py_q) + m_q[54:15];
        5'd9:  sz_q <= 40'(jpz) + 40'(pz_q) + m_q[54:15];
        5'd11: sx_q <= sx_q + m_q[54:15];
        5'd13: sy_q <= sy_q + m_q[54:15];
        5'd15: sz_q <= sz_q + m_q[54:15];
        default: ;
      endcase
    end
    if (state_q == StJSq && step_q == 5'd3) begin
      sq_neg_q <= sq_t[33];
      sq_v_q   <= sq_t[31:0];
      sq_r_q   <= '0;
      sq_bit_q <= 32'h4000_0000;
    end else if (state_q == StJRt) begin
      sq_v_q   <= sq_v_d;
      sq_r_q   <= sq_r_d;
      sq_bit_q <= sq_bit_q >> 2;
    end
    if (emit_go) begin
      vert_x_o    <= clamp_x[31:0];
      vert_y_o    <= clamp_y[31:0];
      vert_z_o    <= clamp_z[31:0];
      saturated_o <= clamp_x[32] | clamp_y[32] | clamp_z[32];
    end
  end

`ifndef ASSERT_OFF
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWMac) |-> (step_q <= WLastStep))
    else $error("weight sequencer step out of range");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("joint table read and write in the same cycle");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |=> (out_valid_q && acc_x_q == '0 && acc_y_q == '0 && acc_z_q == '0))
    else $error("emit did not load the output and clear the accumulators");
`endif

endmodule

// ===== dv/testbench.sv =====
// Testbench for md5_weight_skinning_unit: joint loads and vertex weights with a
// built-in skinning predictor and a result scoreboard. Depends on md5ws_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int JointCount = md5ws_pkg::JointCount;
  localparam logic OpLoadJoint  = 1'b0;
  localparam logic OpApplyWeight = 1'b1;
  localparam longint AccMax = 64'sh7FFF_FFFF_FFFF;
  localparam longint AccMin = -AccMax - 1;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               sat;
  } vertex_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic operation_i = 1'b0;
  logic [5:0] joint_index_i = '0;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [15:0] quat_x_i = '0, quat_y_i = '0, quat_z_i = '0;
  logic [16:0] bias_i = '0;
  logic last_weight_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] vert_x_o, vert_y_o, vert_z_o;
  logic saturated_o;

  md5_weight_skinning_unit DUT (.*);

  // Predictor state.
  longint jpos_x [JointCount];
  longint jpos_y [JointCount];
  longint jpos_z [JointCount];
  longint jq_x [JointCount], jq_y [JointCount], jq_z [JointCount], jq_w [JointCount];
  bit     joint_written [JointCount];
  longint vacc_x, vacc_y, vacc_z;
  vertex_t pending_vertices[$];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  errors = 0;
  longint cycles = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint root_floor(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint acc_sat(longint a, longint p);
    longint s;
    s = a + p;
    if (s > AccMax) return AccMax;
    if (s < AccMin) return AccMin;
    return s;
  endfunction

  function automatic logic signed [31:0] clamp_coord(longint a, inout logic sat);
    if (a > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (a < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh8000_0000;
    end
    return a[31:0];
  endfunction

  task automatic predict_skinning(logic op, int j, longint px, longint py, longint pz,
                                  longint qx, longint qy, longint qz, longint b,
                                  logic last);
    longint t, w, ux, uy, uz, uw, rx, ry, rz, vx, vy, vz;
    vertex_t v;
    logic sat;
    if (op == OpLoadJoint) begin
      t = (64'sd1 <<< 30) - qx * qx - qy * qy - qz * qz;
      w = (t < 0) ? 0 : -root_floor(t);
      if (w < -32768) w = w + 65536; // w reaches -32768 only when t = 2^30 exactly, which still fits in 16 bits
      w = longint'($signed(w[15:0]));
      jpos_x[j] = px; jpos_y[j] = py; jpos_z[j] = pz;
      jq_x[j] = qx; jq_y[j] = qy; jq_z[j] = qz; jq_w[j] = w;
      joint_written[j] = 1'b1;
      return;
    end
    ux = jq_x[j]; uy = jq_y[j]; uz = jq_z[j]; uw = jq_w[j];
    rx = floor_shift(uy * pz - uz * py, 14);
    ry = floor_shift(uz * px - ux * pz, 14);
    rz = floor_shift(ux * py - uy * px, 14);
    vx = px + floor_shift(uw * rx, 15) + floor_shift(uy * rz - uz * ry, 15);
    vy = py + floor_shift(uw * ry, 15) + floor_shift(uz * rx - ux * rz, 15);
    vz = pz + floor_shift(uw * rz, 15) + floor_shift(ux * ry - uy * rx, 15);
    vacc_x = acc_sat(vacc_x, floor_shift((jpos_x[j] + vx) * b, 16));
    vacc_y = acc_sat(vacc_y, floor_shift((jpos_y[j] + vy) * b, 16));
    vacc_z = acc_sat(vacc_z, floor_shift((jpos_z[j] + vz) * b, 16));
    if (last) begin
      sat = 1'b0;
      v.x = clamp_coord(vacc_x, sat);
      v.y = clamp_coord(vacc_y, sat);
      v.z = clamp_coord(vacc_z, sat);
      v.sat = sat;
      pending_vertices.insert(pending_vertices.size(), v);
      vacc_x = 0; vacc_y = 0; vacc_z = 0;
    end
  endtask

  // Sends one item; the payload holds until the transfer. Valid stays high after
  // a transfer so that the next item can follow at once; idling drops it.
  task automatic send_item(logic op, int j, logic [31:0] px, logic [31:0] py,
                           logic [31:0] pz, logic [15:0] qx, logic [15:0] qy,
                           logic [15:0] qz, logic [16:0] b, logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    operation_i <= op;
    joint_index_i <= j[5:0];
    pos_x_i <= px; pos_y_i <= py; pos_z_i <= pz;
    quat_x_i <= qx; quat_y_i <= qy; quat_z_i <= qz;
    bias_i <= b;
    last_weight_i <= last;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_skinning(op, j, longint'($signed(px)), longint'($signed(py)),
                     longint'($signed(pz)), longint'($signed(qx)),
                     longint'($signed(qy)), longint'($signed(qz)), longint'(b), last);
  endtask

  // Result checker and receiver stall.
  always @(posedge clk_i) begin
    vertex_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_vertices.size() == 0) begin
        $error("unexpected vertex x=%0d y=%0d z=%0d", vert_x_o, vert_y_o, vert_z_o);
        errors++;
      end else begin
        e = pending_vertices.pop_front();
        if (vert_x_o !== e.x) begin
          $error("vert_x expected %0d actual %0d", e.x, vert_x_o); errors++;
        end
        if (vert_y_o !== e.y) begin
          $error("vert_y expected %0d actual %0d", e.y, vert_y_o); errors++;
        end
        if (vert_z_o !== e.z) begin
          $error("vert_z expected %0d actual %0d", e.z, vert_z_o); errors++;
        end
        if (saturated_o !== e.sat) begin
          $error("saturated expected %0d actual %0d", e.sat, saturated_o); errors++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [15:0] rand_quat();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(46340)) - 23170);
      2: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      default: return 16'($signed($urandom_range(18000)) - 9000);
    endcase
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000);
    endcase
  endfunction

  function automatic logic [16:0] rand_bias();
    case ($urandom_range(3))
      0: return 17'($urandom);
      1: return 17'd65536;
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  task automatic load_random_joint(int j);
    send_item(OpLoadJoint, j, rand_pos(), rand_pos(), rand_pos(), rand_quat(),
              rand_quat(), rand_quat(), 17'($urandom), 1'($urandom_range(1)));
  endtask

  // A random joint that has been written already.
  function automatic int pick_joint();
    int j;
    do j = $urandom_range(JointCount - 1); while (!joint_written[j]);
    return j;
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_item(OpLoadJoint, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(OpLoadJoint, 63, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              16'h7FFF, 16'h8000, 16'h7FFF, 17'h1FFFF, 1'b1);
    send_item(OpLoadJoint, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              16'h8000, 16'h8000, 16'h8000, 0, 0);
    send_item(OpLoadJoint, 2, 32'h0001_0000, 32'hFFFF_0000, 0,
              16'h5A82, 0, 0, 0, 0);
    send_item(OpApplyWeight, 0, 32'h0001_0000, 0, 0, 0, 0, 0, 17'd65536, 1);
    send_item(OpApplyWeight, 63, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              0, 0, 0, 17'h1FFFF, 1);
    send_item(OpApplyWeight, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              16'hFFFF, 16'hFFFF, 16'hFFFF, 17'h1FFFF, 0);
    send_item(OpApplyWeight, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              0, 0, 0, 17'h1FFFF, 1);
    repeat (4) send_item(OpApplyWeight, 63, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         0, 0, 0, 17'h1FFFF, 0);
    send_item(OpApplyWeight, 2, 32'h0003_0000, 32'h0002_0000, 32'hFFFF_0000,
              0, 0, 0, 0, 1);
    send_item(OpApplyWeight, 2, 32'h0003_0000, 32'h0002_0000, 32'hFFFF_0000,
              0, 0, 0, 17'd32768, 0);
    send_item(OpApplyWeight, 0, 0, 0, 0, 0, 0, 0, 17'd32768, 1);
    wait_drained();
  endtask

  task automatic test_random(int items, int idle_pct, int stall_pct);
    int n, k;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    n = 0;
    while (n < items) begin
      if ($urandom_range(9) == 0) begin
        load_random_joint($urandom_range(JointCount - 1));
        n++;
      end else begin
        // A vertex of one to four weights.
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++) begin
          send_item(OpApplyWeight, pick_joint(), rand_pos(), rand_pos(), rand_pos(),
                    16'($urandom), 16'($urandom), 16'($urandom), rand_bias(), i == k - 1);
          n++;
        end
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    vacc_x = 0; vacc_y = 0; vacc_z = 0;
    foreach (joint_written[i]) joint_written[i] = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    for (int j = 0; j < JointCount; j++) load_random_joint(j);
    test_random(450, 0, 0);
    test_random(450, 66, 0);
    wait_drained();
    test_random(450, 0, 66);
    test_random(450, 31, 31);
    in_valid_i <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending_vertices.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
